[rtl/core/zcdp_pkg.sv]
// Shared types and constants for the ZIP central directory parser.
package zcdp_pkg;

    // Fixed part of one central directory record.
    localparam int HEADER_BYTES = 46;
    localparam int SIG_BYTES    = 4;

    typedef logic [5:0]  t_pos;
    typedef logic [17:0] t_skip;

    // Header byte offsets of the latched little-endian fields.
    localparam t_pos POS_SIG_END = t_pos'(SIG_BYTES);
    localparam t_pos POS_METHOD  = t_pos'(10);
    localparam t_pos POS_USIZE   = t_pos'(24);
    localparam t_pos POS_NAME    = t_pos'(28);
    localparam t_pos POS_EXTRA   = t_pos'(30);
    localparam t_pos POS_COMMENT = t_pos'(32);
    localparam t_pos POS_LHO     = t_pos'(42);
    localparam t_pos POS_LAST    = t_pos'(HEADER_BYTES - 1);

    // Central directory signature, first byte first.
    localparam logic [7:0] CD_SIGNATURE [SIG_BYTES] = '{8'h50, 8'h4B, 8'h01, 8'h02};

    localparam int OUT_TDATA_W = 112;

    typedef struct packed {
        logic [15:0] record_number;
        logic [15:0] comp_method;
        logic [31:0] uncompressed_size;
        logic [15:0] fname_len;
        logic [31:0] hdr_offset;
        logic        bad_signature;
    } t_result;

endpackage

[rtl/core/zcdp_front.sv]
// Front end: walks the record byte stream, latches header fields, builds results.
module zcdp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_restart,
    output logic             o_push,
    output zcdp_pkg::t_result o_result
);

    zcdp_pkg::t_pos  r_pos, n_pos, e_pos;
    zcdp_pkg::t_skip r_skip, n_skip, e_skip;
    logic [15:0] r_rec, n_rec, e_rec;
    logic        r_halt, n_halt, e_halt;
    logic [15:0] r_method, n_method;
    logic [31:0] r_usize, n_usize;
    logic [15:0] r_name_len, n_name_len;
    logic [15:0] r_extra_len, n_extra_len;
    logic [15:0] r_comment_len, n_comment_len;
    logic [31:0] r_lho, n_lho;
    logic [5:0]  w_usize_off, w_lho_off;
    zcdp_pkg::t_skip w_tail;

    always_comb begin
        // Restart clears position, skip count, record count and halt first.
        e_pos  = i_restart ? '0 : r_pos;
        e_skip = i_restart ? '0 : r_skip;
        e_rec  = i_restart ? '0 : r_rec;
        e_halt = i_restart ? 1'b0 : r_halt;

        n_pos         = e_pos;
        n_skip        = e_skip;
        n_rec         = e_rec;
        n_halt        = e_halt;
        n_method      = r_method;
        n_usize       = r_usize;
        n_name_len    = r_name_len;
        n_extra_len   = r_extra_len;
        n_comment_len = r_comment_len;
        n_lho         = r_lho;
        o_push        = 1'b0;
        o_result      = '0;
        w_usize_off   = e_pos - zcdp_pkg::POS_USIZE;
        w_lho_off     = e_pos - zcdp_pkg::POS_LHO;
        w_tail        = '0;

        if (!e_halt) begin
            if (e_skip != '0) begin
                n_skip = e_skip - 18'd1;
                if (n_skip == '0) begin
                    o_push = 1'b1;
                end
            end else if (e_pos < zcdp_pkg::POS_SIG_END &&
                         i_data_byte != zcdp_pkg::CD_SIGNATURE[e_pos[1:0]]) begin
                n_halt = 1'b1;
                n_pos  = '0;
                o_push = 1'b1;
                o_result.bad_signature = 1'b1;
            end else begin
                if (e_pos == zcdp_pkg::POS_METHOD)
                    n_method[7:0] = i_data_byte;
                if (e_pos == zcdp_pkg::POS_METHOD + 6'd1)
                    n_method[15:8] = i_data_byte;
                if (e_pos >= zcdp_pkg::POS_USIZE && e_pos < zcdp_pkg::POS_USIZE + 6'd4)
                    n_usize[{w_usize_off[1:0], 3'b000} +: 8] = i_data_byte;
                if (e_pos == zcdp_pkg::POS_NAME)
                    n_name_len[7:0] = i_data_byte;
                if (e_pos == zcdp_pkg::POS_NAME + 6'd1)
                    n_name_len[15:8] = i_data_byte;
                if (e_pos == zcdp_pkg::POS_EXTRA)
                    n_extra_len[7:0] = i_data_byte;
                if (e_pos == zcdp_pkg::POS_EXTRA + 6'd1)
                    n_extra_len[15:8] = i_data_byte;
                if (e_pos == zcdp_pkg::POS_COMMENT)
                    n_comment_len[7:0] = i_data_byte;
                if (e_pos == zcdp_pkg::POS_COMMENT + 6'd1)
                    n_comment_len[15:8] = i_data_byte;
                if (e_pos >= zcdp_pkg::POS_LHO && e_pos <= zcdp_pkg::POS_LAST)
                    n_lho[{w_lho_off[1:0], 3'b000} +: 8] = i_data_byte;

                if (e_pos >= zcdp_pkg::POS_LAST) begin
                    // Header done: skip name, extra and comment bytes.
                    w_tail = {2'b00, n_name_len} + {2'b00, n_extra_len}
                           + {2'b00, n_comment_len};
                    n_pos  = '0;
                    n_skip = w_tail;
                    if (w_tail == '0) begin
                        o_push = 1'b1;
                    end
                end else begin
                    n_pos = e_pos + 6'd1;
                end
            end
        end

        if (o_push) begin
            o_result.record_number = e_rec;
            n_rec = e_rec + 16'd1;
            if (!o_result.bad_signature) begin
                o_result.comp_method       = n_method;
                o_result.uncompressed_size = n_usize;
                o_result.fname_len         = n_name_len;
                o_result.hdr_offset        = n_lho;
            end
        end

        o_push = o_push & i_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_skip        <= '0;
            r_rec         <= '0;
            r_halt        <= 1'b0;
            r_method      <= '0;
            r_usize       <= '0;
            r_name_len    <= '0;
            r_extra_len   <= '0;
            r_comment_len <= '0;
            r_lho         <= '0;
        end else if (i_accept) begin
            r_pos         <= n_pos;
            r_skip        <= n_skip;
            r_rec         <= n_rec;
            r_halt        <= n_halt;
            r_method      <= n_method;
            r_usize       <= n_usize;
            r_name_len    <= n_name_len;
            r_extra_len   <= n_extra_len;
            r_comment_len <= n_comment_len;
            r_lho         <= n_lho;
        end
    end

endmodule

[rtl/core/zcdp_queue.sv]
// Result queue between the front end and the output stage.
module zcdp_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  zcdp_pkg::t_result i_result,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output zcdp_pkg::t_result o_result
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    zcdp_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign o_empty  = (r_count == '0);
    assign o_result = r_mem[r_rd_ptr];

    always_comb begin
        w_push   = i_push & ~o_full;
        w_pop    = i_pop & ~o_empty;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push)
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        if (w_pop)
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        if (w_push && !w_pop)
            n_count = r_count + CNT_W'(1);
        else if (w_pop && !w_push)
            n_count = r_count - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push)
            r_mem[r_wr_ptr] <= i_result;
    end

endmodule

[rtl/core/zcdp_back.sv]
// Output stage: pulls results from the queue into a registered master port.
module zcdp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  zcdp_pkg::t_result i_result,
    output logic              o_pop,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output zcdp_pkg::t_result o_out_result
);

    logic              r_valid, n_valid;
    zcdp_pkg::t_result r_result;

    assign o_pop        = ~i_empty & (~r_valid | i_out_ready);
    assign o_out_valid  = r_valid;
    assign o_out_result = r_result;

    always_comb begin
        n_valid = r_valid;
        if (o_pop)
            n_valid = 1'b1;
        else if (i_out_ready)
            n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop)
            r_result <= i_result;
    end

endmodule

[rtl/core/zip_central_directory_parser_core.sv]
// Top level of the ZIP central directory parser.
// Usage: feed the central directory one byte per transaction on the s_axis
// channel; s_axis_tuser marks the first byte of a new directory (restart),
// which clears the record count, the header position, any pending skip and
// a halt caused by a bad signature. Each 46-byte record header is checked
// for the 50 4B 01 02 signature, its fields are latched, and the name,
// extra and comment bytes that follow are skipped. One result transaction
// leaves on m_axis when the last byte of a record is taken, or at once on
// a signature mismatch (m_axis_tuser = 1, fields other than record_number
// zero), after which bytes are dropped until a restart.
// Throughput: one byte per cycle while s_axis_tready is high; the front end
// does all work for a byte in the cycle it is accepted. Path: a result is
// written into the queue on the edge that takes the byte ending the record,
// then loaded from the queue into the output register.
// Backpressure: results wait in a QUEUE_DEPTH-entry queue behind the output
// register; s_axis_tready drops only once the queue is full, so the input
// keeps flowing while m_axis is stalled briefly.
// Reset: i_rst_n is synchronous, active low; it clears all parser state,
// empties the queue and drops m_axis_tvalid.
module zip_central_directory_parser_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tuser,   // [0] restart
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] record_number, [31:16] comp_method,
    // [63:32] uncompressed_size, [79:64] fname_len,
    // [111:80] hdr_offset
    output logic [zcdp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic         m_axis_tuser    // [0] bad_signature
);

    logic              w_accept;
    logic              w_push;
    zcdp_pkg::t_result w_front_result;
    logic              w_full, w_empty, w_pop;
    zcdp_pkg::t_result w_queue_result;
    zcdp_pkg::t_result w_out_result;

    // Accept a byte whenever the queue can take the result it might cause.
    assign s_axis_tready = ~w_full;
    assign w_accept      = s_axis_tvalid & s_axis_tready;

    zcdp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (s_axis_tdata),
        .i_restart   (s_axis_tuser),
        .o_push      (w_push),
        .o_result    (w_front_result)
    );

    zcdp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_front_result),
        .i_pop    (w_pop),
        .o_full   (w_full),
        .o_empty  (w_empty),
        .o_result (w_queue_result)
    );

    zcdp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_result     (w_queue_result),
        .o_pop        (w_pop),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_result (w_out_result)
    );

    // Pack result fields, first field in the lowest bits.
    assign m_axis_tdata = {w_out_result.hdr_offset,
                           w_out_result.fname_len,
                           w_out_result.uncompressed_size,
                           w_out_result.comp_method,
                           w_out_result.record_number};
    assign m_axis_tuser = w_out_result.bad_signature;

endmodule

[rtl/core/zcdp_checker.sv]
// Port-level checks for the ZIP central directory parser, bound to the top level.
module zcdp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [zcdp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tuser
);

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("m_axis_tvalid high after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // A bad signature result carries only its record number.
    a_bad_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[zcdp_pkg::OUT_TDATA_W-1:16] == '0)
        else $error("bad signature result has nonzero fields");

    // Input backpressure only while a result is waiting at the output.
    a_stall_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

endmodule

bind zip_central_directory_parser_core zcdp_checker u_zcdp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
